// ===== design/rpis_pkg.sv =====
// ----------------------------------------------------------------------------
// rpis_pkg: shared constants and functions for the indexed set with random pick
// Sizes, command codes, sequencer states and the xorshift step.
// ----------------------------------------------------------------------------
package rpis_pkg;

    localparam int CAPACITY   = 1024;
    localparam int ELEM_W     = $clog2(CAPACITY);
    localparam int COUNT_W    = ELEM_W + 1;
    localparam int SEED_W     = 56;
    localparam int RNG_W      = 32;
    localparam int DIV_CNT_W  = $clog2(RNG_W + 1);

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;
    localparam logic [1:0] CMD_PICK   = 2'd2;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_READ   = 3'd1;
    localparam logic [2:0] ST_RMW    = 3'd2;
    localparam logic [2:0] ST_DIV    = 3'd3;
    localparam logic [2:0] ST_FETCH  = 3'd4;
    localparam logic [2:0] ST_WAIT   = 3'd5;
    localparam logic [2:0] ST_OUT    = 3'd6;
    localparam logic [2:0] ST_CLEAR  = 3'd7;

    function automatic logic [RNG_W-1:0] xs_mix(input logic [RNG_W-1:0] a);
        logic [RNG_W-1:0] t;
        t = a ^ (a << 16);
        t = t ^ (t >> 5);
        t = t ^ (t << 1);
        return t;
    endfunction

endpackage

// ===== design/random_pick_indexed_set.sv =====
// ----------------------------------------------------------------------------
// random_pick_indexed_set: dense indexed set with xorshift random pick
// Sequence: an insert, remove or unused code, or a pick on an empty set, goes
// through READ, WAIT and RMW to OUT; a pick goes through READ, DIV (32-step
// restoring remainder), FETCH (one slot read) and RMW to OUT.
// One transaction at a time; the next is accepted the cycle after the result is taken.
// Reset: synchronous active low; count is zero, the generator is loaded from
// seed 1, and a pass over all 1024 entries clears the membership memory before s_tready.
// ----------------------------------------------------------------------------
module random_pick_indexed_set (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [1:0] cmd, [11:2] element_id
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [0] pick_valid, [10:1] picked_element, [21:11] member_count
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    localparam int EW = rpis_pkg::ELEM_W;
    localparam int CW = rpis_pkg::COUNT_W;
    localparam int RW = rpis_pkg::RNG_W;

    logic          flag_mem [rpis_pkg::CAPACITY];
    logic [EW-1:0] sof_mem [rpis_pkg::CAPACITY];
    logic [EW-1:0] slot_mem [rpis_pkg::CAPACITY];
    logic [EW-1:0] sof_rd_reg, slot_rd_reg;
    logic          flag_rd_reg;

    logic [2:0]  state_reg;
    logic [1:0]  cmd_reg;
    logic [EW-1:0] id_reg;
    logic [EW-1:0] clr_reg;
    logic [CW-1:0] size_reg;
    logic [rpis_pkg::SEED_W-1:0] seed_reg;
    logic [RW-1:0] wa_reg, wb_reg, wc_reg;
    logic [RW-1:0] quo_reg;
    logic [CW-1:0] rem_reg;
    logic [rpis_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic        pv_reg;
    logic [EW-1:0] pe_reg;

    logic cfg_wr;
    logic [CW:0] rem_sh;
    logic [RW-1:0] t_val;

    assign pready   = 1'b1;
    assign cfg_wr   = psel & penable & pwrite & (paddr == 3'd0);
    assign prdata   = (paddr == 3'd0) ? {8'd0, seed_reg} : 64'd0;
    assign s_tready = (state_reg == rpis_pkg::ST_IDLE);
    assign m_tvalid = (state_reg == rpis_pkg::ST_OUT);
    assign m_tdata  = {2'd0, size_reg, pe_reg, pv_reg};
    assign rem_sh   = {rem_reg, quo_reg[RW-1]};
    assign t_val    = rpis_pkg::xs_mix(wa_reg);

    // memory ports: reads always registered
    logic [EW-1:0] sof_ra, slot_ra, sof_wa, slot_wa, sof_wd, slot_wd;
    logic sof_we, slot_we;
    logic [EW-1:0] flag_wa;
    logic flag_we, flag_wd;

    always_ff @(posedge aclk) begin
        if (sof_we) begin
            sof_mem[sof_wa] <= sof_wd;
        end
        sof_rd_reg <= sof_mem[sof_ra];
        if (slot_we) begin
            slot_mem[slot_wa] <= slot_wd;
        end
        slot_rd_reg <= slot_mem[slot_ra];
        if (flag_we) begin
            flag_mem[flag_wa] <= flag_wd;
        end
        flag_rd_reg <= flag_mem[id_reg];
    end

    logic [EW-1:0] last_idx;
    logic          do_ins, do_rem;
    assign last_idx = EW'(size_reg - CW'(1));
    assign do_ins = (cmd_reg == rpis_pkg::CMD_INSERT) && !flag_rd_reg
                    && (size_reg < CW'(rpis_pkg::CAPACITY));
    assign do_rem = (cmd_reg == rpis_pkg::CMD_REMOVE) && flag_rd_reg;

    always_comb begin
        sof_ra  = id_reg;
        slot_ra = last_idx;
        sof_we  = 1'b0;
        slot_we = 1'b0;
        sof_wa  = id_reg;
        sof_wd  = EW'(size_reg);
        slot_wa = EW'(size_reg);
        slot_wd = id_reg;
        flag_we = 1'b0;
        flag_wa = id_reg;
        flag_wd = 1'b0;
        if (state_reg == rpis_pkg::ST_CLEAR) begin
            flag_we = 1'b1;
            flag_wa = clr_reg;
        end
        if (state_reg == rpis_pkg::ST_FETCH) begin
            slot_ra = EW'(rem_reg);
        end
        if (state_reg == rpis_pkg::ST_RMW) begin
            if (do_ins) begin
                sof_we  = 1'b1;
                slot_we = 1'b1;
                flag_we = 1'b1;
                flag_wd = 1'b1;
            end else if (do_rem) begin
                flag_we = 1'b1;
                if (slot_rd_reg != id_reg) begin
                    sof_we  = 1'b1;
                    sof_wa  = slot_rd_reg;
                    sof_wd  = sof_rd_reg;
                    slot_we = 1'b1;
                    slot_wa = sof_rd_reg;
                    slot_wd = slot_rd_reg;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rpis_pkg::ST_CLEAR;
            clr_reg   <= '0;
            size_reg  <= '0;
            seed_reg  <= rpis_pkg::SEED_W'(1);
            wa_reg    <= 32'd1;
            wb_reg    <= '0;
            wc_reg    <= '0;
        end else begin
            if (cfg_wr) begin
                seed_reg <= pwdata[rpis_pkg::SEED_W-1:0];
                wa_reg   <= pwdata[31:0];
                wb_reg   <= pwdata[43:12];
                wc_reg   <= pwdata[55:24];
            end
            unique case (state_reg)
                rpis_pkg::ST_CLEAR: begin
                    clr_reg <= clr_reg + EW'(1);
                    if (clr_reg == EW'(rpis_pkg::CAPACITY - 1)) begin
                        state_reg <= rpis_pkg::ST_IDLE;
                    end
                end
                rpis_pkg::ST_IDLE: begin
                    if (s_tvalid) begin
                        cmd_reg   <= s_tdata[1:0];
                        id_reg    <= s_tdata[11:2];
                        pv_reg    <= 1'b0;
                        pe_reg    <= '0;
                        state_reg <= rpis_pkg::ST_READ;
                    end
                end
                rpis_pkg::ST_READ: begin
                    if (cmd_reg == rpis_pkg::CMD_PICK && size_reg != '0) begin
                        quo_reg   <= t_val;
                        rem_reg   <= '0;
                        cnt_reg   <= '0;
                        wa_reg    <= wb_reg;
                        wb_reg    <= wc_reg;
                        wc_reg    <= t_val ^ wb_reg ^ wc_reg;
                        state_reg <= rpis_pkg::ST_DIV;
                    end else begin
                        state_reg <= rpis_pkg::ST_WAIT;
                    end
                end
                rpis_pkg::ST_WAIT: begin
                    state_reg <= rpis_pkg::ST_RMW;
                end
                rpis_pkg::ST_RMW: begin
                    if (do_ins) begin
                        size_reg <= size_reg + CW'(1);
                    end else if (do_rem) begin
                        size_reg <= size_reg - CW'(1);
                    end
                    state_reg <= rpis_pkg::ST_OUT;
                end
                rpis_pkg::ST_DIV: begin
                    quo_reg <= {quo_reg[RW-2:0], 1'b0};
                    if (rem_sh >= {1'b0, size_reg}) begin
                        rem_reg <= CW'(rem_sh - {1'b0, size_reg});
                    end else begin
                        rem_reg <= CW'(rem_sh);
                    end
                    cnt_reg <= cnt_reg + rpis_pkg::DIV_CNT_W'(1);
                    if (cnt_reg == rpis_pkg::DIV_CNT_W'(RW - 1)) begin
                        state_reg <= rpis_pkg::ST_FETCH;
                    end
                end
                rpis_pkg::ST_FETCH: begin
                    pv_reg    <= 1'b1;
                    state_reg <= rpis_pkg::ST_RMW;
                end
                rpis_pkg::ST_OUT: begin
                    if (m_tready) begin
                        state_reg <= rpis_pkg::ST_IDLE;
                    end
                end
                default: state_reg <= rpis_pkg::ST_IDLE;
            endcase
            if (state_reg == rpis_pkg::ST_RMW && pv_reg) begin
                pe_reg <= slot_rd_reg;
            end
        end
    end

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: random_pick_indexed_set
// Drives insert, remove, pick and unused-code transactions with random stalls on both sides
// and checks every result against an internal model of the set and generator.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] CMD_SPARE = 2'd3;
    localparam logic [2:0] REG_SEED  = 3'd0;

    class set_scoreboard;
        bit [rpis_pkg::CAPACITY-1:0]     member;
        logic [rpis_pkg::ELEM_W-1:0]     slot_of [rpis_pkg::CAPACITY];
        logic [rpis_pkg::ELEM_W-1:0]     slots [rpis_pkg::CAPACITY];
        logic [rpis_pkg::COUNT_W-1:0]    count;
        logic [rpis_pkg::RNG_W-1:0]      wa, wb, wc;
        logic [23:0]                     pending [$];
        int                              errors;

        function void load_seed(logic [rpis_pkg::SEED_W-1:0] seed);
            wa = seed[31:0];
            wb = seed[43:12];
            wc = 32'(seed >> 24);
        endfunction

        function void clear();
            member = '0;
            count = '0;
            errors = 0;
            load_seed(1);
        endfunction

        function void note_input(logic [1:0] cmd, logic [rpis_pkg::ELEM_W-1:0] id);
            logic [rpis_pkg::RNG_W-1:0] t;
            logic [rpis_pkg::ELEM_W-1:0] hole, last;
            logic valid;
            logic [rpis_pkg::ELEM_W-1:0] pick;
            logic [23:0] item;
            valid = 0;
            pick = '0;
            case (cmd)
                rpis_pkg::CMD_INSERT: begin
                    if (!member[id] && count < rpis_pkg::CAPACITY) begin
                        member[id] = 1;
                        slot_of[id] = count[rpis_pkg::ELEM_W-1:0];
                        slots[count[rpis_pkg::ELEM_W-1:0]] = id;
                        count++;
                    end
                end
                rpis_pkg::CMD_REMOVE: begin
                    if (member[id] && count > 0) begin
                        hole = slot_of[id];
                        last = slots[count - 1];
                        member[id] = 0;
                        if (last != id) begin
                            slot_of[last] = hole;
                            slots[hole] = last;
                        end
                        count--;
                    end
                end
                rpis_pkg::CMD_PICK: begin
                    if (count > 0) begin
                        t = wa;
                        t ^= t << 16;
                        t ^= t >> 5;
                        t ^= t << 1;
                        wa = wb;
                        wb = wc;
                        wc = t ^ wa ^ wb;
                        valid = 1;
                        pick = slots[t % count];
                    end
                end
                default: ;
            endcase
            item = {2'b0, count, pick, valid};
            pending.insert(pending.size(), item);
        endfunction

        function void check_result(logic [23:0] got);
            logic [23:0] want;
            if (pending.size() == 0) begin
                $error("unexpected result %h", got);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got[0] !== want[0]) begin
                $error("pick_valid exp %0d got %0d", want[0], got[0]);
                errors++;
            end
            if (got[10:1] !== want[10:1]) begin
                $error("picked_element exp %0d got %0d", want[10:1], got[10:1]);
                errors++;
            end
            if (got[21:11] !== want[21:11]) begin
                $error("member_count exp %0d got %0d", want[21:11], got[21:11]);
                errors++;
            end
        endfunction
    endclass

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [23:0] m_tdata;
    logic        psel = 0, penable = 0, pwrite = 0;
    logic [2:0]  paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic        pready;

    set_scoreboard sb = new();
    int  cycles = 0;
    bit  calm = 0;
    bit  hold_off = 0;

    always #5 aclk = ~aclk;

    random_pick_indexed_set dut (.*);

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > 2000000) begin
            $display("testbench: errors");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata);
    end

    // receiver: random stall bursts, long hold-off on request
    initial begin
        int n;
        @(posedge aclk);
        forever begin
            if (hold_off) begin
                m_tready <= 0;
                repeat (400) @(posedge aclk);
                hold_off = 0;
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                m_tready <= 0;
                n = $urandom_range(1, 12);
                repeat (n) @(posedge aclk);
            end else begin
                m_tready <= 1;
                @(posedge aclk);
            end
        end
    end

    task automatic send(logic [1:0] cmd, logic [rpis_pkg::ELEM_W-1:0] id);
        int n;
        if (!calm && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 0;
            n = $urandom_range(1, 12);
            repeat (n) @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tdata <= {4'b0, id, cmd};
        do @(posedge aclk); while (!s_tready);
        sb.note_input(cmd, id);
    endtask

    task automatic drain();
        int guard;
        s_tvalid <= 0;
        guard = 0;
        while (sb.pending.size() != 0 && guard < 100000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (50) @(posedge aclk);
    endtask

    task automatic write_seed(logic [rpis_pkg::SEED_W-1:0] seed);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= REG_SEED; pwdata <= 64'(seed);
        @(posedge aclk);
        penable <= 1;
        @(posedge aclk);
        psel <= 0; penable <= 0; pwrite <= 0;
        sb.load_seed(seed);
    endtask

    task automatic random_phase(int items, int span);
        int r;
        for (int i = 0; i < items; i++) begin
            r = $urandom_range(0, 99);
            if (r < 40)      send(rpis_pkg::CMD_INSERT, 10'($urandom_range(0, span - 1)));
            else if (r < 65) send(rpis_pkg::CMD_REMOVE, 10'($urandom_range(0, span - 1)));
            else if (r < 97) send(rpis_pkg::CMD_PICK, 10'($urandom));
            else             send(CMD_SPARE, 10'($urandom));
        end
    endtask

    initial begin
        sb.clear();
        repeat (2) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed
        send(rpis_pkg::CMD_PICK, 10'd0);
        send(rpis_pkg::CMD_REMOVE, 10'd5);
        send(rpis_pkg::CMD_INSERT, 10'd0);
        send(rpis_pkg::CMD_INSERT, 10'd1023);
        send(rpis_pkg::CMD_INSERT, 10'd1023);
        send(rpis_pkg::CMD_INSERT, 10'h2AA);
        send(rpis_pkg::CMD_INSERT, 10'h155);
        send(rpis_pkg::CMD_PICK, 10'h3FF);
        send(rpis_pkg::CMD_PICK, 10'd0);
        send(rpis_pkg::CMD_REMOVE, 10'd0);
        send(rpis_pkg::CMD_REMOVE, 10'd0);
        send(rpis_pkg::CMD_PICK, 10'd0);
        send(CMD_SPARE, 10'h3FF);
        send(rpis_pkg::CMD_REMOVE, 10'h155);
        send(rpis_pkg::CMD_REMOVE, 10'd1023);
        send(rpis_pkg::CMD_REMOVE, 10'h2AA);
        send(rpis_pkg::CMD_PICK, 10'd0);
        drain();

        write_seed('0);
        random_phase(150, 16);
        drain();
        write_seed({rpis_pkg::SEED_W{1'b1}});
        hold_off = 1;
        random_phase(200, 64);
        drain();
        write_seed(56'($urandom) << 24 | 56'($urandom));
        random_phase(250, 1024);
        drain();

        random_phase(500, 1024);
        calm = 1;
        random_phase(230, 32);
        drain();
        s_tvalid <= 0;

        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
design/rpis_pkg.sv
design/random_pick_indexed_set.sv
tb/testbench.sv
